[hw/rtl/hlc_pkg.sv]
`default_nettype none

package hlc_pkg;

  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned CACHE_ENTRIES = 1 << SLOT_W;
  localparam int unsigned MAX_NAME_LEN  = 64;
  localparam int unsigned NAME_IDX_W    = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int unsigned COUNT_W       = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned ENAME_AW      = SLOT_W + NAME_IDX_W;
  localparam int unsigned ENAME_DEPTH   = CACHE_ENTRIES << NAME_IDX_W;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_NAME  = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_CHECK,
    S_CMP,
    S_FILL
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] name_byte;
    logic       last;
    logic [7:0] backend_id;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  found_backend;
    logic        cacheable;
    logic [31:0] name_hash;
  } out_t;

  typedef struct packed {
    logic byte_en;
    logic fill_accept;
    logic clear;
    logic cnt_inc;
    logic cnt_clr;
    logic fill_wr;
    logic emit;
    logic emit_hit;
    logic arm_fill;
  } cmd_t;

  typedef struct packed {
    logic fill_pending;
    logic cacheable;
    logic meta_ok;
    logic byte_eq;
    logic lookup_last;
    logic fill_last;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/hlc_ctrl.sv]
`default_nettype none

module hlc_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  wire logic [1:0]   op_i,
  input  wire logic         last_i,
  input  wire hlc_pkg::sts_t sts_i,
  output hlc_pkg::cmd_t     cmd_o,
  output logic              busy,
  output logic              done_o
);

  hlc_pkg::state_e state_q, state_d;
  logic            done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlc_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hlc_pkg::S_IDLE: begin
        if (start) begin
          if (op_i == hlc_pkg::OP_NAME && last_i) begin
            state_d = hlc_pkg::S_META;
          end else if (op_i == hlc_pkg::OP_FILL && sts_i.fill_pending) begin
            state_d = hlc_pkg::S_FILL;
          end
        end
      end
      hlc_pkg::S_META: state_d = hlc_pkg::S_CHECK;
      hlc_pkg::S_CHECK: begin
        state_d = sts_i.meta_ok ? hlc_pkg::S_CMP : hlc_pkg::S_IDLE;
      end
      hlc_pkg::S_CMP: begin
        if (!sts_i.byte_eq || sts_i.lookup_last) begin
          state_d = hlc_pkg::S_IDLE;
        end
      end
      hlc_pkg::S_FILL: begin
        if (sts_i.fill_last) begin
          state_d = hlc_pkg::S_IDLE;
        end
      end
      default: state_d = hlc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      hlc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (op_i)
            hlc_pkg::OP_NAME:  cmd_o.byte_en     = 1'b1;
            hlc_pkg::OP_FILL:  cmd_o.fill_accept = 1'b1;
            hlc_pkg::OP_CLEAR: cmd_o.clear       = 1'b1;
            default: ;
          endcase
        end
      end
      hlc_pkg::S_META: ;
      hlc_pkg::S_CHECK: begin
        if (!sts_i.meta_ok) begin
          cmd_o.emit     = 1'b1;
          cmd_o.arm_fill = sts_i.cacheable;
          cmd_o.cnt_clr  = 1'b1;
        end
      end
      hlc_pkg::S_CMP: begin
        if (!sts_i.byte_eq) begin
          cmd_o.emit     = 1'b1;
          cmd_o.arm_fill = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
        end else if (sts_i.lookup_last) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_hit = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      hlc_pkg::S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.cnt_clr = 1'b1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign done_d = cmd_o.emit;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/hlc_dp.sv]
`default_nettype none

module hlc_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hlc_pkg::in_t  in_i,
  input  wire hlc_pkg::cmd_t cmd_i,
  output hlc_pkg::sts_t      sts_o,
  output hlc_pkg::out_t      res_o
);

  localparam int unsigned SW = hlc_pkg::SLOT_W;
  localparam int unsigned IW = hlc_pkg::NAME_IDX_W;
  localparam int unsigned CW = hlc_pkg::COUNT_W;

  logic [31:0]  hash_q, hash_d;
  logic [CW-1:0] count_q, count_d;
  logic         over_q, over_d;
  logic         pend_q, pend_d;
  logic [31:0]  pend_hash_q, pend_hash_d;
  logic [CW-1:0] pend_len_q, pend_len_d;
  logic [hlc_pkg::CACHE_ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0] cnt_q, cnt_d;
  hlc_pkg::out_t res_q;

  logic [7:0]   name_buf [hlc_pkg::MAX_NAME_LEN];
  logic [31:0]  ent_hash [hlc_pkg::CACHE_ENTRIES];
  logic [CW-1:0] ent_len [hlc_pkg::CACHE_ENTRIES];
  logic [7:0]   ent_bid  [hlc_pkg::CACHE_ENTRIES];
  logic [7:0]   ent_name [hlc_pkg::ENAME_DEPTH];

  logic [7:0]   buf_rd_q;
  logic [7:0]   ename_rd_q;
  logic [31:0]  hash_rd_q;
  logic [CW-1:0] len_rd_q;
  logic [7:0]   bid_rd_q;

  logic [SW-1:0] look_slot, pend_slot;
  logic [31:0]  hash_mix;
  logic         buf_room;
  logic         cacheable;
  logic [CW-1:0] cnt_next;

  assign look_slot = hash_q[SW-1:0];
  assign pend_slot = pend_hash_q[SW-1:0];
  assign hash_mix  = hash_q ^ {24'd0, in_i.name_byte};
  assign buf_room  = count_q < CW'(hlc_pkg::MAX_NAME_LEN);
  assign cacheable = !over_q && (count_q != '0);
  assign cnt_next  = CW'(cnt_q) + CW'(1);

  always_comb begin
    hash_d      = hash_q;
    count_d     = count_q;
    over_d      = over_q;
    pend_d      = pend_q;
    pend_hash_d = pend_hash_q;
    pend_len_d  = pend_len_q;
    valid_d     = valid_q;
    if (cmd_i.byte_en) begin
      hash_d = hash_mix * hlc_pkg::HASH_PRIME;
      pend_d = 1'b0;
      if (buf_room) begin
        count_d = count_q + CW'(1);
      end else begin
        over_d = 1'b1;
      end
    end
    if (cmd_i.fill_accept) begin
      pend_d = 1'b0;
      if (pend_q) begin
        valid_d[pend_slot] = 1'b1;
      end
    end
    if (cmd_i.clear) begin
      valid_d = '0;
      pend_d  = 1'b0;
    end
    if (cmd_i.emit) begin
      hash_d  = hlc_pkg::HASH_BASIS;
      count_d = '0;
      over_d  = 1'b0;
      if (cmd_i.arm_fill) begin
        pend_d      = 1'b1;
        pend_hash_d = hash_q;
        pend_len_d  = count_q;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= hlc_pkg::HASH_BASIS;
      count_q     <= '0;
      over_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_hash_q <= '0;
      pend_len_q  <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
    end else begin
      hash_q      <= hash_d;
      count_q     <= count_d;
      over_q      <= over_d;
      pend_q      <= pend_d;
      pend_hash_q <= pend_hash_d;
      pend_len_q  <= pend_len_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en && buf_room) begin
      name_buf[count_q[IW-1:0]] <= in_i.name_byte;
    end
    buf_rd_q <= name_buf[cnt_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_accept && pend_q) begin
      ent_hash[pend_slot] <= pend_hash_q;
      ent_len[pend_slot]  <= pend_len_q;
      ent_bid[pend_slot]  <= in_i.backend_id;
    end
    hash_rd_q <= ent_hash[look_slot];
    len_rd_q  <= ent_len[look_slot];
    bid_rd_q  <= ent_bid[look_slot];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      ent_name[{pend_slot, cnt_q}] <= buf_rd_q;
    end
    ename_rd_q <= ent_name[{look_slot, cnt_d}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.hit           <= cmd_i.emit_hit;
      res_q.found_backend <= cmd_i.emit_hit ? bid_rd_q : 8'd0;
      res_q.cacheable     <= cacheable;
      res_q.name_hash     <= hash_q;
    end
  end

  assign sts_o.fill_pending = pend_q;
  assign sts_o.cacheable    = cacheable;
  assign sts_o.meta_ok      = cacheable && valid_q[look_slot] &&
                              (hash_rd_q == hash_q) && (len_rd_q == count_q);
  assign sts_o.byte_eq      = buf_rd_q == ename_rd_q;
  assign sts_o.lookup_last  = cnt_next == count_q;
  assign sts_o.fill_last    = cnt_next == pend_len_q;
  assign res_o              = res_q;

endmodule

`default_nettype wire

[hw/rtl/hostname_lookup_cache_unit.sv]
// A name byte that is not last leaves busy low, so bytes stream one per cycle while idle.
// On the last byte a lookup runs through META and CHECK, where an early miss ends it; a full
// compare of an L-byte name goes on in CMP, one byte per cycle, before the result strobe.
// A fill keeps busy high while the buffered name is copied; clear and ignored items leave it low.
// The receiver cannot stall: done_o is high for one cycle and the block is free again then.
// Reset clears control state and all valid bits at once; no clearing pass follows.
`default_nettype none

module hostname_lookup_cache_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  wire hlc_pkg::in_t in_i,
  output logic              busy,
  output logic              done_o,
  output hlc_pkg::out_t     res_o
);

  hlc_pkg::cmd_t cmd;
  hlc_pkg::sts_t sts;

  hlc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (in_i.op),
    .last_i (in_i.last),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  hlc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

`ifndef SYNTHESIS
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result strobe without a lookup in progress");

  a_hit_cacheable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> res_o.cacheable) else $error("hit on an uncacheable name");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.found_backend == 8'd0))
    else $error("miss reports a nonzero backend");

  a_last_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op == hlc_pkg::OP_NAME && in_i.last) |=> busy)
    else $error("last name byte did not start a lookup");
`endif

endmodule

`default_nettype wire
